>>> rtl/rhash_pkg.sv
// Shared types and constants for the seeded rapidhash core.
`timescale 1ns / 1ps
package rhash_pkg;

   localparam logic [63:0] SEC0 = 64'h2d358dccaa6c78a5;
   localparam logic [63:0] SEC1 = 64'h8bb84b93962eacc9;
   localparam logic [63:0] SEC2 = 64'h4b33a62ed433d4a3;

   // One classified input beat as it travels from front to back.
   typedef struct packed {
      logic [63:0] word;
      logic [3:0]  cnt;
      logic        first;
      logic        last;
      logic        short_bad;
      logic [31:0] length;
      logic [63:0] seed;
   } item_type;

endpackage

>>> rtl/rhash_front.sv
// Front end: accepts input beats, clamps the byte count and masks unused bytes.
`timescale 1ns / 1ps
module rhash_front (
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [63:0]          req_data_word,
   input  logic [3:0]           req_byte_count,
   input  logic                 req_first_word,
   input  logic                 req_last_word,
   input  logic [31:0]          req_message_length,
   input  logic [63:0]          req_message_seed,
   input  logic                 q_full,
   output logic                 q_push,
   output rhash_pkg::item_type  q_item
);
   import rhash_pkg::*;

   logic [3:0]  cnt;
   logic [63:0] masked;

   always_comb begin
      cnt = (req_byte_count > 4'd8) ? 4'd8 : req_byte_count;
      for (int k = 0; k < 8; k++) begin
         masked[8*k +: 8] = (4'(k) < cnt) ? req_data_word[8*k +: 8] : 8'd0;
      end
   end

   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      q_item.word      = masked;
      q_item.cnt       = cnt;
      q_item.first     = req_first_word;
      q_item.last      = req_last_word;
      q_item.short_bad = !req_last_word && (cnt != 4'd8);
      q_item.length    = req_message_length;
      q_item.seed      = req_message_seed;
   end

endmodule

>>> rtl/rhash_fifo.sv
// Two-entry queue between the front end and the hash engine.
`timescale 1ns / 1ps
module rhash_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  rhash_pkg::item_type  push_item,
   output logic                 full,
   input  logic                 pop,
   output logic                 valid,
   output rhash_pkg::item_type  head
);
   import rhash_pkg::*;

   item_type   mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full  = (count_ff == 2'd2);
   assign valid = (count_ff != 2'd0);
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> rtl/rhash_mul.sv
// 64x64->128 multiplier built from four 32x32 partial products accumulated in sequence.
`timescale 1ns / 1ps
module rhash_mul (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [63:0]   op_a,
   input  logic [63:0]   op_b,
   output logic          done,
   output logic [127:0]  product
);
   logic         busy_ff, busy_in;
   logic [2:0]   step_ff, step_in;
   logic [63:0]  pp_ff, pp_in;
   logic [127:0] acc_ff, acc_in;
   logic         done_ff, done_in;
   logic [31:0]  fa, fb;
   logic [6:0]   sh;

   always_comb begin
      unique case (step_ff)
         3'd0:    begin fa = op_a[31:0];  fb = op_b[31:0];  end
         3'd1:    begin fa = op_a[63:32]; fb = op_b[31:0];  end
         3'd2:    begin fa = op_a[31:0];  fb = op_b[63:32]; end
         default: begin fa = op_a[63:32]; fb = op_b[63:32]; end
      endcase
      // shift for the product registered in the previous step
      unique case (step_ff)
         3'd2, 3'd3: sh = 7'd32;
         3'd4:       sh = 7'd64;
         default:    sh = 7'd0;
      endcase
   end

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      pp_in   = pp_ff;
      acc_in  = acc_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         step_in = 3'd0;
         acc_in  = 128'd0;
      end else if (busy_ff) begin
         pp_in = 64'(fa) * 64'(fb);
         if (step_ff != 3'd0) begin
            acc_in = acc_ff + (128'(pp_ff) << sh);
         end
         if (step_ff == 3'd4) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
         step_in = step_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      pp_ff  <= pp_in;
      acc_ff <= acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= 3'd0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
         done_ff <= done_in;
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

>>> rtl/rhash_back.sv
// Hash engine: lane state, chunk sequencing, finalization and result register.
`timescale 1ns / 1ps
module rhash_back #(
   parameter int LENGTH_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  rhash_pkg::item_type  q_head,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [63:0]          rsp_hash_value,
   output logic                 rsp_length_mismatch
);
   import rhash_pkg::*;

   localparam int LB = LENGTH_BITS;

   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_BULK  = 3'd1;
   localparam logic [2:0] PH_TAIL  = 3'd2;
   localparam logic [2:0] PH_TAIL2 = 3'd3;
   localparam logic [2:0] PH_DONE  = 3'd4;
   localparam logic [2:0] PH_BAD   = 3'd5;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_SEEDW = 4'd1;
   localparam logic [3:0] S_STEP  = 4'd2;
   localparam logic [3:0] S_MIXW  = 4'd3;
   localparam logic [3:0] S_POST  = 4'd4;
   localparam logic [3:0] S_FIN1W = 4'd5;
   localparam logic [3:0] S_FIN2W = 4'd6;
   localparam logic [3:0] S_OUT   = 4'd7;

   logic [3:0]    state_ff, state_in;
   logic [2:0]    phase_ff, phase_in;
   logic [1:0]    slot_ff, slot_in;
   logic [63:0]   lane0_ff, lane0_in, lane1_ff, lane1_in, lane2_ff, lane2_in;
   logic [LB-1:0] left_ff, left_in, seen_ff, seen_in;
   logic [63:0]   rw0_ff, rw0_in, rw1_ff, rw1_in, rw2_ff, rw2_in;
   logic [63:0]   opx_ff, opx_in, opy_ff, opy_in;
   logic [63:0]   res_hash_ff, res_hash_in;
   logic          res_bad_ff, res_bad_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [63:0]   rsp_hash_ff, rsp_hash_in;
   logic          rsp_bad_ff, rsp_bad_in;

   logic           mul_start, mul_done;
   logic [127:0]   prod;
   logic [63:0]    mix, lo, hi;

   rhash_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (opx_ff),
      .op_b    (opy_ff),
      .done    (mul_done),
      .product (prod)
   );

   assign lo  = prod[63:0];
   assign hi  = prod[127:64];
   assign mix = opx_ff ^ lo ^ opy_ff ^ hi;

   function automatic logic [63:0] rd8(input logic [255:0] tb, input logic [4:0] at);
      logic [255:0] t;
      t = tb >> {at, 3'b000};
      return t[63:0];
   endfunction

   function automatic logic [31:0] rd4(input logic [255:0] tb, input logic [4:0] at);
      logic [63:0] t;
      t = rd8(tb, at);
      return t[31:0];
   endfunction

   function automatic logic [7:0] rd1(input logic [255:0] tb, input logic [4:0] at);
      logic [63:0] t;
      t = rd8(tb, at);
      return t[7:0];
   endfunction

   // step bookkeeping
   logic [LB-1:0] len_ext, cnt_l, take, left_n, seen_n;
   logic [2:0]    ph_s;
   logic          pair, mix_go;
   logic [63:0]   step_x, step_y;

   // finalization operands
   logic [255:0] tb;
   logic [4:0]   end5, l5, s5, pl5, d5;
   logic [63:0]  fin_a, fin_b, len64, seed_mix;

   always_comb begin
      len_ext = LB'(q_head.length);
      cnt_l   = LB'(q_head.cnt);
      ph_s    = phase_ff;
      if (q_head.short_bad) ph_s = PH_BAD;
      if (cnt_l > left_ff) begin
         ph_s = PH_BAD;
         take = left_ff;
      end else begin
         take = cnt_l;
      end
      pair   = (ph_s != PH_BAD) && (q_head.cnt == 4'd8) && seen_ff[3];
      left_n = left_ff - take;
      seen_n = seen_ff + take;
      mix_go = pair && ((ph_s == PH_BULK) ||
               (((ph_s == PH_TAIL) || (ph_s == PH_TAIL2)) && (left_n != '0)));
      step_x = rw2_ff ^ SEC2;
      step_y = q_head.word ^ lane0_ff;
      if (ph_s == PH_BULK) begin
         unique case (slot_ff)
            2'd0:    begin step_x = rw2_ff ^ SEC0; step_y = q_head.word ^ lane0_ff; end
            2'd1:    begin step_x = rw2_ff ^ SEC1; step_y = q_head.word ^ lane1_ff; end
            default: begin step_x = rw2_ff ^ SEC2; step_y = q_head.word ^ lane2_ff; end
         endcase
      end else if (ph_s == PH_TAIL) begin
         step_y = q_head.word ^ lane0_ff ^ SEC1;
      end
      seed_mix = q_head.seed ^ mix ^ 64'(len_ext);
   end

   always_comb begin
      tb    = {64'd0, rw2_ff, rw1_ff, rw0_ff};
      len64 = 64'(seen_ff);
      l5    = seen_ff[4:0];
      end5  = 5'd17 + {2'b00, seen_ff[2:0] - 3'd1};
      s5    = end5 - l5;
      pl5   = s5 + l5 - 5'd4;
      d5    = (seen_ff[4] || seen_ff[3]) ? 5'd4 : 5'd0;
      fin_a = 64'd0;
      fin_b = 64'd0;
      if (seen_ff != '0) begin
         if (seen_ff <= LB'(16)) begin
            if (seen_ff >= LB'(4)) begin
               fin_a = {rd4(tb, s5), rd4(tb, pl5)};
               fin_b = {rd4(tb, s5 + d5), rd4(tb, pl5 - d5)};
            end else begin
               fin_a = {rd1(tb, s5), 16'd0, rd1(tb, s5 + (l5 >> 1)),
                        24'd0, rd1(tb, s5 + l5 - 5'd1)};
            end
         end else begin
            fin_a = rd8(tb, end5 - 5'd16);
            fin_b = rd8(tb, end5 - 5'd8);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      slot_in      = slot_ff;
      lane0_in     = lane0_ff;
      lane1_in     = lane1_ff;
      lane2_in     = lane2_ff;
      left_in      = left_ff;
      seen_in      = seen_ff;
      rw0_in       = rw0_ff;
      rw1_in       = rw1_ff;
      rw2_in       = rw2_ff;
      opx_in       = opx_ff;
      opy_in       = opy_ff;
      res_hash_in  = res_hash_ff;
      res_bad_in   = res_bad_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_hash_in  = rsp_hash_ff;
      rsp_bad_in   = rsp_bad_ff;
      mul_start    = 1'b0;
      q_pop        = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               if (q_head.first) begin
                  opx_in    = q_head.seed ^ SEC0;
                  opy_in    = SEC1;
                  mul_start = 1'b1;
                  state_in  = S_SEEDW;
               end else if (phase_ff == PH_IDLE) begin
                  q_pop = 1'b1;   // drop stray beat
               end else begin
                  state_in = S_STEP;
               end
            end
         end
         S_SEEDW: begin
            if (mul_done) begin
               lane0_in = seed_mix;
               lane1_in = seed_mix;
               lane2_in = seed_mix;
               left_in  = len_ext;
               seen_in  = '0;
               slot_in  = 2'd0;
               rw0_in   = 64'd0;
               rw1_in   = 64'd0;
               rw2_in   = 64'd0;
               phase_in = (len_ext > LB'(48)) ? PH_BULK : PH_TAIL;
               state_in = S_STEP;
            end
         end
         S_STEP: begin
            phase_in = ph_s;
            left_in  = left_n;
            seen_in  = seen_n;
            if (q_head.cnt != 4'd0) begin
               rw0_in = rw1_ff;
               rw1_in = rw2_ff;
               rw2_in = q_head.word;
            end
            if (mix_go) begin
               opx_in    = step_x;
               opy_in    = step_y;
               mul_start = 1'b1;
               state_in  = S_MIXW;
            end else begin
               state_in = S_POST;
            end
         end
         S_MIXW: begin
            if (mul_done) begin
               state_in = S_POST;
               unique case (phase_ff)
                  PH_BULK: begin
                     unique case (slot_ff)
                        2'd0: begin lane0_in = mix; slot_in = 2'd1; end
                        2'd1: begin lane1_in = mix; slot_in = 2'd2; end
                        default: begin
                           lane2_in = mix;
                           slot_in  = 2'd0;
                           if (left_ff < LB'(48)) begin
                              lane0_in = lane0_ff ^ lane1_ff ^ mix;
                              phase_in = PH_TAIL;
                           end
                        end
                     endcase
                  end
                  PH_TAIL: begin lane0_in = mix; phase_in = PH_TAIL2; end
                  default: begin lane0_in = mix; phase_in = PH_DONE; end
               endcase
            end
         end
         S_POST: begin
            if (!q_head.last) begin
               q_pop    = 1'b1;
               state_in = S_IDLE;
            end else if ((phase_ff == PH_BAD) || (left_ff != '0)) begin
               res_hash_in = 64'd0;
               res_bad_in  = 1'b1;
               state_in    = S_OUT;
            end else begin
               opx_in    = fin_a ^ SEC1;
               opy_in    = fin_b ^ lane0_ff;
               mul_start = 1'b1;
               state_in  = S_FIN1W;
            end
         end
         S_FIN1W: begin
            if (mul_done) begin
               opx_in    = opx_ff ^ lo ^ SEC0 ^ len64;
               opy_in    = opy_ff ^ hi ^ SEC1;
               mul_start = 1'b1;
               state_in  = S_FIN2W;
            end
         end
         S_FIN2W: begin
            if (mul_done) begin
               res_hash_in = mix;
               res_bad_in  = 1'b0;
               state_in    = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_hash_in  = res_hash_ff;
               rsp_bad_in   = res_bad_ff;
               phase_in     = PH_IDLE;
               q_pop        = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      rw0_ff      <= rw0_in;
      rw1_ff      <= rw1_in;
      rw2_ff      <= rw2_in;
      opx_ff      <= opx_in;
      opy_ff      <= opy_in;
      res_hash_ff <= res_hash_in;
      res_bad_ff  <= res_bad_in;
      rsp_hash_ff <= rsp_hash_in;
      rsp_bad_ff  <= rsp_bad_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_IDLE;
         slot_ff      <= 2'd0;
         lane0_ff     <= 64'd0;
         lane1_ff     <= 64'd0;
         lane2_ff     <= 64'd0;
         left_ff      <= '0;
         seen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         slot_ff      <= slot_in;
         lane0_ff     <= lane0_in;
         lane1_ff     <= lane1_in;
         lane2_ff     <= lane2_in;
         left_ff      <= left_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_hash_value      = rsp_hash_ff;
   assign rsp_length_mismatch = rsp_bad_ff;

endmodule

>>> rtl/seeded_rapidhash_64_core.sv
// Seeded 64-bit rapidhash core: top level.
`timescale 1ns / 1ps
// Hashes a byte message delivered as little-endian 64-bit beats; the first beat
// also carries the seed and declared length, the last beat yields one result
// (hash 0 with length_mismatch set when the bytes delivered differ from the
// declared length or a beat before the last is not full). A two-beat queue
// decouples the input port from the hash engine. Every product goes through one
// shared multiplier built from 32x32 partial products. A beat that completes
// a word pair can start a mix multiply; a message start adds the seed mix,
// and the last beat adds the two finalizing multiplies plus result handoff.
module seeded_rapidhash_64_core #(
   parameter int LENGTH_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_data_word,
   input  logic [3:0]  req_byte_count,
   input  logic        req_first_word,
   input  logic        req_last_word,
   input  logic [31:0] req_message_length,
   input  logic [63:0] req_message_seed,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_hash_value,
   output logic        rsp_length_mismatch
);
   import rhash_pkg::*;

   logic     q_full, q_push, q_pop, q_valid;
   item_type q_item, q_head;

   rhash_front u_front (
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_word      (req_data_word),
      .req_byte_count     (req_byte_count),
      .req_first_word     (req_first_word),
      .req_last_word      (req_last_word),
      .req_message_length (req_message_length),
      .req_message_seed   (req_message_seed),
      .q_full             (q_full),
      .q_push             (q_push),
      .q_item             (q_item)
   );

   rhash_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_item),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .head      (q_head)
   );

   rhash_back #(.LENGTH_BITS(LENGTH_BITS)) u_back (
      .clock               (clock),
      .reset               (reset),
      .q_valid             (q_valid),
      .q_head              (q_head),
      .q_pop               (q_pop),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_hash_value      (rsp_hash_value),
      .rsp_length_mismatch (rsp_length_mismatch)
   );

endmodule
